@@ sv/cmfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfd_pkg
// Shared types and constants for the CAN motor feedback decoder.
// ----------------------------------------------------------------------------
package cmfd_pkg;

    // Slot layout: chassis motors first, then shooter motors
    localparam int CHASSIS_SLOTS = 6;
    localparam int SHOOT_SLOTS   = 3;
    localparam int TOTAL_SLOTS   = CHASSIS_SLOTS + SHOOT_SLOTS;
    localparam int SLOT_W        = 4;

    // Field widths
    localparam int ID_W    = 11;
    localparam int ENC_W   = 16;
    localparam int TURN_W  = 32;
    localparam int CFG_IDX_W = 3;

    // Unwrap thresholds and angle scale (counts per turn = 2^13)
    localparam logic signed [ENC_W:0] WRAP_HIGH = 17'sd4096;
    localparam logic signed [ENC_W:0] WRAP_LOW  = -17'sd4096;
    localparam int TURN_SHIFT = 13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHASSIS_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_LEFT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_RIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER      = 3'd3;

    // Configuration reset values
    localparam logic [ID_W-1:0] RST_CHASSIS_BASE = 11'd513;
    localparam logic [ID_W-1:0] RST_FIRE_LEFT    = 11'd513;
    localparam logic [ID_W-1:0] RST_FIRE_RIGHT   = 11'd514;
    localparam logic [ID_W-1:0] RST_TRIGGER      = 11'd519;

    typedef struct packed {
        logic [ID_W-1:0] chassis_base_id;
        logic [ID_W-1:0] fire_left_id;
        logic [ID_W-1:0] fire_right_id;
        logic [ID_W-1:0] trigger_id;
    } cfg_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } match_t;

endpackage

@@ sv/cmfd_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfd_match
// Maps bus and CAN identifier to a motor slot.
// ----------------------------------------------------------------------------
module cmfd_match
    import cmfd_pkg::*;
(
    input  cfg_t            cfg,
    input  logic            bus_select,
    input  logic [ID_W-1:0] frame_id,
    output match_t          match
);

    logic [ID_W:0]   chassis_off;
    logic            chassis_hit;
    logic [ID_W-1:0] shoot_ids [3];
    logic            shoot_hit;
    logic [SLOT_W-1:0] shoot_slot;

    // Bus 0: window of consecutive identifiers from the base
    assign chassis_off = {1'b0, frame_id} - {1'b0, cfg.chassis_base_id};
    assign chassis_hit = !chassis_off[ID_W] && (chassis_off < (ID_W+1)'(CHASSIS_SLOTS));

    // Bus 1: first matching identifier wins, so scan from the back
    assign shoot_ids[0] = cfg.fire_left_id;
    assign shoot_ids[1] = cfg.fire_right_id;
    assign shoot_ids[2] = cfg.trigger_id;

    always_comb
    begin
        shoot_hit  = 1'b0;
        shoot_slot = '0;
        for (int k = SHOOT_SLOTS - 1; k >= 0; k--)
        begin
            if (frame_id == shoot_ids[k])
            begin
                shoot_hit  = 1'b1;
                shoot_slot = SLOT_W'(CHASSIS_SLOTS + k);
            end
        end
    end

    always_comb
    begin
        if (!bus_select)
        begin
            match.hit  = chassis_hit;
            match.slot = chassis_hit ? SLOT_W'(chassis_off) : '0;
        end
        else
        begin
            match.hit  = shoot_hit;
            match.slot = shoot_slot;
        end
    end

endmodule

@@ sv/cmfd_unwrap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfd_unwrap
// Per-slot encoder history and multi-turn count, with total angle.
// ----------------------------------------------------------------------------
module cmfd_unwrap
    import cmfd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     upd_en,
    input  logic [SLOT_W-1:0]        slot,
    input  logic [ENC_W-1:0]         encoder,
    output logic signed [TURN_W-1:0] turn_next,
    output logic signed [TURN_W-1:0] angle_next
);

    logic [ENC_W-1:0]  last_enc_reg [TOTAL_SLOTS];
    logic [TURN_W-1:0] turns_reg    [TOTAL_SLOTS];
    logic signed [ENC_W:0] enc_delta;
    logic [TURN_W-1:0] turn_cur;
    logic [TURN_W-1:0] turn_upd;

    // Signed difference against the last encoder of the slot
    assign enc_delta = $signed({1'b0, encoder}) - $signed({1'b0, last_enc_reg[slot]});
    assign turn_cur  = turns_reg[slot];

    always_comb
    begin
        if (enc_delta > WRAP_HIGH)
            turn_upd = turn_cur - TURN_W'(1);
        else if (enc_delta < WRAP_LOW)
            turn_upd = turn_cur + TURN_W'(1);
        else
            turn_upd = turn_cur;
    end

    assign turn_next  = $signed(turn_upd);
    assign angle_next = $signed(((turn_upd + TURN_W'(1)) << TURN_SHIFT)
                                + {{(TURN_W-ENC_W){1'b0}}, encoder});

    // Slot state write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL_SLOTS; i++)
            begin
                last_enc_reg[i] <= '0;
                turns_reg[i]    <= '0;
            end
        end
        else if (upd_en)
        begin
            last_enc_reg[slot] <= encoder;
            turns_reg[slot]    <= turn_upd;
        end
    end

endmodule

@@ sv/can_motor_feedback_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_motor_feedback_decoder_core
// Decodes motor feedback CAN frames and unwraps the encoder into turns.
// ----------------------------------------------------------------------------
// Usage:
//   Frame channel: a beat is taken at a clock edge where start is high and
//   busy is low; busy stays low, so a frame can be given every cycle.
//   Result channel: done is high for one cycle with the result fields; the
//   receiver cannot stall, so it must take the beat in that cycle.
//   Timing: an accepted frame passes the input register and then the result
//   register before done rises with its result. Throughput: one frame per
//   cycle, as busy stays low, set by the read-modify-write of the matched
//   slot's state.
//   Every frame gives one result; an unmatched frame gives hit low and all
//   fields zero, with no state change.
//   Configuration: cfg_valid/cfg_ready write beat with cfg_index and
//   cfg_data; cfg_ready is always high. Indexes above 3 are ignored. Write
//   only while no frame is in flight.
//   Reset: identifiers return to their defaults, encoder history and turn
//   counts of all slots clear, no result is pending.
// ----------------------------------------------------------------------------
module can_motor_feedback_decoder_core
    import cmfd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Frame channel
    input  logic                     start,
    output logic                     busy,
    input  logic                     bus_select,
    input  logic [ID_W-1:0]          frame_id,
    input  logic [7:0]               byte0,
    input  logic [7:0]               byte1,
    input  logic [7:0]               byte2,
    input  logic [7:0]               byte3,
    input  logic [7:0]               byte4,
    input  logic [7:0]               byte5,
    input  logic [7:0]               byte6,
    // Result channel
    output logic                     done,
    output logic                     hit,
    output logic [SLOT_W-1:0]        slot,
    output logic [ENC_W-1:0]         encoder,
    output logic signed [15:0]       speed,
    output logic signed [15:0]       current,
    output logic [7:0]               temperature,
    output logic signed [TURN_W-1:0] turn_count,
    output logic signed [TURN_W-1:0] multiturn_angle,
    // Configuration channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [ID_W-1:0]          cfg_data
);

    cfg_t cfg_reg;

    logic            in_valid_reg;
    logic            bus_reg;
    logic [ID_W-1:0] id_reg;
    logic [7:0]      bytes_reg [7];

    match_t          match;
    logic [ENC_W-1:0] enc_dec;
    logic signed [TURN_W-1:0] turn_next;
    logic signed [TURN_W-1:0] angle_next;
    logic            upd_en;

    logic                     done_reg;
    logic                     hit_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [ENC_W-1:0]         enc_reg;
    logic [15:0]              speed_reg;
    logic [15:0]              current_reg;
    logic [7:0]               temp_reg;
    logic [TURN_W-1:0]        turn_reg;
    logic [TURN_W-1:0]        angle_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chassis_base_id <= RST_CHASSIS_BASE;
            cfg_reg.fire_left_id    <= RST_FIRE_LEFT;
            cfg_reg.fire_right_id   <= RST_FIRE_RIGHT;
            cfg_reg.trigger_id      <= RST_TRIGGER;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CHASSIS_BASE: cfg_reg.chassis_base_id <= cfg_data;
                REG_FIRE_LEFT:    cfg_reg.fire_left_id    <= cfg_data;
                REG_FIRE_RIGHT:   cfg_reg.fire_right_id   <= cfg_data;
                REG_TRIGGER:      cfg_reg.trigger_id      <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            bus_reg      <= bus_select;
            id_reg       <= frame_id;
            bytes_reg[0] <= byte0;
            bytes_reg[1] <= byte1;
            bytes_reg[2] <= byte2;
            bytes_reg[3] <= byte3;
            bytes_reg[4] <= byte4;
            bytes_reg[5] <= byte5;
            bytes_reg[6] <= byte6;
        end
    end

    // Slot lookup
    cmfd_match u_match
    (
        .cfg        (cfg_reg),
        .bus_select (bus_reg),
        .frame_id   (id_reg),
        .match      (match)
    );

    // Big-endian encoder, state update on a matched beat
    assign enc_dec = {bytes_reg[0], bytes_reg[1]};
    assign upd_en  = in_valid_reg && match.hit;

    cmfd_unwrap u_unwrap
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd_en     (upd_en),
        .slot       (match.slot),
        .encoder    (enc_dec),
        .turn_next  (turn_next),
        .angle_next (angle_next)
    );

    // Result register; unmatched frames give all-zero fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            hit_reg <= match.hit;
            if (match.hit)
            begin
                slot_reg    <= match.slot;
                enc_reg     <= enc_dec;
                speed_reg   <= {bytes_reg[2], bytes_reg[3]};
                current_reg <= {bytes_reg[4], bytes_reg[5]};
                temp_reg    <= bytes_reg[6];
                turn_reg    <= turn_next;
                angle_reg   <= angle_next;
            end
            else
            begin
                slot_reg    <= '0;
                enc_reg     <= '0;
                speed_reg   <= '0;
                current_reg <= '0;
                temp_reg    <= '0;
                turn_reg    <= '0;
                angle_reg   <= '0;
            end
        end
    end

    assign done            = done_reg;
    assign hit             = hit_reg;
    assign slot            = slot_reg;
    assign encoder         = enc_reg;
    assign speed           = $signed(speed_reg);
    assign current         = $signed(current_reg);
    assign temperature     = temp_reg;
    assign turn_count      = $signed(turn_reg);
    assign multiturn_angle = $signed(angle_reg);

endmodule

@@ sv/cmfd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfd_checker
// Port-level checks for the CAN motor feedback decoder, bound to the top.
// ----------------------------------------------------------------------------
module cmfd_checker
    import cmfd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     done,
    input  logic                     hit,
    input  logic [SLOT_W-1:0]        slot,
    input  logic [ENC_W-1:0]         encoder,
    input  logic signed [TURN_W-1:0] turn_count,
    input  logic signed [TURN_W-1:0] multiturn_angle
);

    // Every accepted frame gives a result after the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted frame produced no result");

    // Unmatched frame reports zeros
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (slot == '0 && encoder == '0 && turn_count == '0
                            && multiturn_angle == '0))
        else $error("unmatched result carries nonzero fields");

    // Matched slot lies within the slot map
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (slot < SLOT_W'(TOTAL_SLOTS)))
        else $error("slot out of range");

    // Angle is consistent with turn count and encoder
    a_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (multiturn_angle == (((turn_count + 32'sd1) <<< TURN_SHIFT)
                                               + $signed({16'd0, encoder}))))
        else $error("total angle inconsistent with turn count");

endmodule

bind can_motor_feedback_decoder_core cmfd_checker u_cmfd_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .hit             (hit),
    .slot            (slot),
    .encoder         (encoder),
    .turn_count      (turn_count),
    .multiturn_angle (multiturn_angle)
);
